FILE: hw/rtl/vndp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vndp_pkg;

  localparam int SAMPLE_W          = 8;
  localparam int BYTE_W            = 8;
  localparam int POS_W             = 3;
  localparam int DCOUNT_W          = 2;
  localparam int DBITS_W           = 3;
  localparam int MAX_PAIRS         = 4;
  localparam int PAIRS_PER_SAMPLE  = 3;
  localparam logic [DCOUNT_W-1:0] DCOUNT_MAX = 2'd3;

  typedef struct packed {
    logic                byte_valid;
    logic [BYTE_W-1:0]   packed_byte;
    logic [DCOUNT_W-1:0] discard_count;
    logic [DBITS_W-1:0]  discard_bits;
  } vndp_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/von_neumann_debias_packer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Von Neumann debiaser and byte packer. Each accepted sample yields exactly one
// result transaction: the low 2*PAIRS_PER_SAMPLE bits are read as bit pairs from
// bit 0 up, unequal pairs contribute their lower bit to a byte built LSB first,
// and equal pairs are reported as discarded bits. One sample is accepted every
// clock cycle while the output side takes results. The sample lands in the
// input register at acceptance, and the result register is loaded from the
// single-pass pair logic when the sample moves on, which the output side can
// hold off. The packing state advances when a sample moves into the result
// register, so results keep sample order.

module von_neumann_debias_packer_top
  import vndp_pkg::*;
#(
  parameter int PAIRS_PER_SAMPLE = vndp_pkg::PAIRS_PER_SAMPLE
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     byte_valid,
  output logic [BYTE_W-1:0]        packed_byte,
  output logic [DCOUNT_W-1:0]      discard_count,
  output logic [DBITS_W-1:0]       discard_bits
);

  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [BYTE_W-1:0]   accumulator;
  logic [BYTE_W-1:0]   accumulator_next;
  logic [POS_W-1:0]    bit_position;
  logic [POS_W-1:0]    bit_position_next;
  vndp_result_t        result_next;
  vndp_result_t        result;
  logic                out_free;
  logic                move;

  assign out_free = !out_valid || !out_stall;
  assign move     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  vndp_pair_pack #(
    .PAIRS(PAIRS_PER_SAMPLE)
  ) u_pair_pack (
    .sample            (s1_sample),
    .accumulator       (accumulator),
    .bit_position      (bit_position),
    .result            (result_next),
    .accumulator_next  (accumulator_next),
    .bit_position_next (bit_position_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator  <= '0;
      bit_position <= '0;
    end else if (move) begin
      accumulator  <= accumulator_next;
      bit_position <= bit_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      result <= result_next;
    end
  end

  assign byte_valid    = result.byte_valid;
  assign packed_byte   = result.packed_byte;
  assign discard_count = result.discard_count;
  assign discard_bits  = result.discard_bits;

  // A result without a completed byte carries a zero byte.
  a_packed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> packed_byte == '0)
    else $error("packed_byte nonzero without byte_valid");

  // With a zero discard count, the discarded bits stay clear.
  a_dbits_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && discard_count == '0 |-> discard_bits == '0)
    else $error("discard_bits set with zero discard_count");

  // The discard count cannot exceed the number of pairs examined.
  a_dcount_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(discard_count) <= PAIRS_PER_SAMPLE)
    else $error("discard_count exceeds pair count");

  // Packing state only advances when a sample moves into the result register.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !move |=> $stable(accumulator) && $stable(bit_position))
    else $error("packing state changed without a sample transaction");

  // Input is only held off while the first stage is occupied.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("in_stall raised with room in the pipeline");

endmodule

`default_nettype wire

FILE: hw/rtl/vndp_pair_pack.sv
`timescale 1ns / 1ps
`default_nettype none

module vndp_pair_pack
  import vndp_pkg::*;
#(
  parameter int PAIRS = PAIRS_PER_SAMPLE
) (
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic [BYTE_W-1:0]   accumulator,
  input  wire logic [POS_W-1:0]    bit_position,
  output vndp_result_t             result,
  output logic [BYTE_W-1:0]        accumulator_next,
  output logic [POS_W-1:0]         bit_position_next
);

  localparam int USED_PAIRS = (PAIRS < MAX_PAIRS) ? PAIRS : MAX_PAIRS;

  logic [BYTE_W-1:0]   acc;
  logic [POS_W-1:0]    pos;
  logic                valid;
  logic [BYTE_W-1:0]   packed_val;
  logic [DCOUNT_W-1:0] dcount;
  logic [DBITS_W-1:0]  dbits;
  logic                lo;
  logic                hi;

  // Pairs are handled in order from the low end; at most one byte can
  // complete per sample since a sample holds at most four kept bits.
  always_comb begin
    acc        = accumulator;
    pos        = bit_position;
    valid      = 1'b0;
    packed_val = '0;
    dcount     = '0;
    dbits      = '0;
    lo         = 1'b0;
    hi         = 1'b0;
    for (int p = 0; p < USED_PAIRS; p++) begin
      lo = sample[2*p];
      hi = sample[2*p+1];
      if (lo != hi) begin
        acc[pos] = acc[pos] | lo;
        if (pos == POS_W'(BYTE_W - 1)) begin
          valid      = 1'b1;
          packed_val = acc;
          acc        = '0;
          pos        = '0;
        end else begin
          pos = pos + POS_W'(1);
        end
      end else if (dcount != DCOUNT_MAX) begin
        dbits[dcount] = lo;
        dcount        = dcount + DCOUNT_W'(1);
      end
    end
  end

  always_comb begin
    result.byte_valid    = valid;
    result.packed_byte   = packed_val;
    result.discard_count = dcount;
    result.discard_bits  = dbits;
    accumulator_next     = acc;
    bit_position_next    = pos;
  end

endmodule

`default_nettype wire
